// File: sv/cbe_pkg.sv
package cbe_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_CARD  = 2'd2,
    OP_FAIL  = 2'd3
  } opcode_t;

  localparam logic [1:0] DST_CARD = 2'd0;
  localparam logic [1:0] DST_HOST = 2'd1;
  localparam logic [1:0] DST_DONE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LINK    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic [3:0] KIND_I_LAST  = 4'h0;
  localparam logic [3:0] KIND_I_CHAIN = 4'h1;
  localparam logic [3:0] KIND_R_ACK   = 4'hA;
  localparam logic [3:0] KIND_S_WTX   = 4'hF;

  localparam logic [7:0] PCB_I_LAST  = 8'h02;
  localparam logic [7:0] PCB_I_CHAIN = 8'h12;
  localparam logic [7:0] PCB_R_ACK   = 8'hA2;
  localparam logic [7:0] WTX_MASK    = 8'h3F;

  localparam logic [1:0] CFG_CID   = 2'd0;
  localparam logic [1:0] CFG_LIMIT = 2'd1;

  // work kinds passed from front to back
  typedef enum logic [2:0] {
    CMD_SEND  = 3'd0,
    CMD_HOST  = 3'd1,
    CMD_DONE  = 3'd2,
    CMD_SHORT = 3'd3,
    CMD_NONE  = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] b0;
    logic       has_tail;
    logic [7:0] tail;
    logic [1:0] status;
    logic [15:0] len;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_PCB   = 3'd1,
    BK_CID   = 3'd2,
    BK_RDREQ = 3'd3,
    BK_DATA  = 3'd4,
    BK_TAIL  = 3'd5,
    BK_ONE   = 3'd6
  } bk_state_t;

endpackage

// File: sv/cbe_front.sv
module cbe_front #(
  parameter int PAYLOAD_DEPTH = 256,
  localparam int CW = $clog2(PAYLOAD_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [7:0]        data_byte,
  input  logic              frame_end,
  input  logic              cid_en,
  output cbe_pkg::cmd_t     cmd,
  output logic              cmd_push,
  input  logic              cmd_full,
  output logic              wr_en,
  output logic [CW-1:0]     wr_addr,
  output logic [7:0]        wr_data,
  output logic [CW-1:0]     count,
  input  logic              send_busy
);
  import cbe_pkg::*;

  logic [CW-1:0] count_r, count_nxt;
  logic          tog_r, tog_nxt;
  logic          act_r, act_nxt;
  logic [6:0]    idx_r, idx_nxt;
  logic [7:0]    hdr_r, hdr_nxt;
  logic [7:0]    wtx_r, wtx_nxt;
  logic [15:0]   tot_r, tot_nxt;
  logic [7:0]    hdr_use;
  logic [3:0]    kind;
  logic [6:0]    hlen;
  logic          tog_hit;

  // hold input until the queue is empty and the back stage is idle, so a pending send has fetched count
  assign in_ready = !cmd_full && !send_busy;
  assign count = count_r;
  assign hlen = cid_en ? 7'd2 : 7'd1;
  assign hdr_use = (idx_r == 7'd0) ? data_byte : hdr_r;
  assign kind = hdr_use[7:4];
  assign tog_hit = hdr_use[0] == tog_r;

  always_comb begin
    count_nxt = count_r; tog_nxt = tog_r; act_nxt = act_r; idx_nxt = idx_r;
    hdr_nxt = hdr_r; wtx_nxt = wtx_r; tot_nxt = tot_r;
    cmd = '0; cmd.kind = CMD_NONE; cmd_push = 1'b0;
    wr_en = 1'b0; wr_addr = count_r; wr_data = data_byte;
    if (in_valid && in_ready) begin
      unique case (opcode_t'(opcode))
        OP_LOAD: begin
          if (!act_r && count_r < CW'(PAYLOAD_DEPTH)) begin
            wr_en = 1'b1; count_nxt = count_r + 1'b1;
          end
        end
        OP_START: begin
          if (!act_r) begin
            act_nxt = 1'b1; tot_nxt = '0; idx_nxt = '0;
            cmd_push = 1'b1; cmd.kind = CMD_SEND; cmd.has_tail = 1'b1;
            cmd.b0 = {7'd0, tog_r};
          end
        end
        OP_FAIL: begin
          if (act_r) begin
            cmd_push = 1'b1; cmd.kind = CMD_DONE; cmd.status = ST_LINK;
            cmd.len = tot_r;
            act_nxt = 1'b0; count_nxt = '0; idx_nxt = '0;
          end
        end
        default: begin
          if (act_r) begin
            if (idx_r == 7'd0) begin
              hdr_nxt = data_byte; wtx_nxt = '0;
            end
            if (idx_r >= hlen) begin
              if (kind == KIND_I_LAST || kind == KIND_I_CHAIN) begin
                cmd_push = 1'b1; cmd.kind = CMD_HOST; cmd.b0 = data_byte;
                if (tot_r != 16'hFFFF) tot_nxt = tot_r + 1'b1;
              end else if (kind == KIND_S_WTX && idx_r == hlen) begin
                wtx_nxt = data_byte;
              end
            end
            if (idx_r != 7'd127) idx_nxt = idx_r + 1'b1;
            if (frame_end) begin
              idx_nxt = '0;
              // a host byte and the frame's reply never coincide for R/S kinds;
              // for I kinds both share one entry
              if (kind == KIND_I_LAST || kind == KIND_I_CHAIN || kind == KIND_R_ACK) begin
                if (tog_hit) tog_nxt = !tog_r;
              end
              if (!(idx_r >= hlen && (kind == KIND_I_LAST || kind == KIND_I_CHAIN))) begin
                cmd_push = 1'b1;
                priority case (kind)
                  KIND_I_LAST: begin
                    cmd.kind = CMD_DONE; cmd.status = ST_OK; cmd.len = tot_r;
                    act_nxt = 1'b0; count_nxt = '0;
                  end
                  KIND_I_CHAIN: begin
                    cmd.kind = CMD_SHORT;
                    cmd.b0 = PCB_R_ACK | {4'd0, cid_en, 2'd0, tog_nxt};
                  end
                  KIND_R_ACK: begin
                    cmd.kind = CMD_SEND; cmd.b0 = {7'd0, tog_nxt};
                  end
                  KIND_S_WTX: begin
                    cmd.kind = CMD_SHORT; cmd.b0 = hdr_use; cmd.has_tail = 1'b1;
                    cmd.tail = ((idx_r == hlen) ? data_byte :
                                (idx_r == 7'd0 ? 8'd0 : wtx_r)) & WTX_MASK;
                  end
                  default: begin
                    cmd.kind = CMD_DONE; cmd.status = ST_UNKNOWN; cmd.len = tot_r;
                    act_nxt = 1'b0; count_nxt = '0;
                  end
                endcase
              end else begin
                // host byte plus the closing reply: fold both into one entry
                cmd.has_tail = 1'b1;
                if (kind == KIND_I_LAST) begin
                  cmd.kind = CMD_DONE; cmd.status = ST_OK; cmd.len = tot_nxt;
                  act_nxt = 1'b0; count_nxt = '0;
                end else begin
                  cmd.tail = PCB_R_ACK | {4'd0, cid_en, 2'd0, tog_nxt};
                end
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; tog_r <= 1'b0; act_r <= 1'b0; idx_r <= '0;
      hdr_r <= '0; wtx_r <= '0; tot_r <= '0;
    end else begin
      count_r <= count_nxt; tog_r <= tog_nxt; act_r <= act_nxt; idx_r <= idx_nxt;
      hdr_r <= hdr_nxt; wtx_r <= wtx_nxt; tot_r <= tot_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cmd_push |-> !cmd_full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !act_r)
    else $error("load during exchange");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && opcode == OP_FAIL && act_r) |=> !act_r)
    else $error("link failure did not end exchange");
endmodule

// File: sv/cbe_queue.sv
module cbe_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cbe_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output cbe_pkg::cmd_t dout
);
  import cbe_pkg::*;

  cmd_t       mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] n_r, n_nxt;

  assign full = n_r == 3'd4;
  assign empty = n_r == 3'd0;
  assign dout = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r + {1'b0, push};
    rp_nxt = rp_r + {1'b0, pop};
    n_nxt = n_r + {2'd0, push} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; n_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; n_r <= n_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) n_r <= 3'd4)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> n_r == $past(n_r) + 3'd1)
    else $error("queue count slip");
endmodule

// File: sv/cbe_back.sv
module cbe_back #(
  parameter int PAYLOAD_DEPTH = 256,
  parameter int MAX_FRAME = 64,
  localparam int CW = $clog2(PAYLOAD_DEPTH + 1),
  localparam int AW = $clog2(PAYLOAD_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cid_en,
  input  logic [6:0]    limit_raw,
  input  cbe_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  logic [CW-1:0] count,
  output logic          send_busy,
  input  logic          wr_en,
  input  logic [CW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata,
  output logic [1:0]    out_tuser,
  output logic          out_tlast
);
  import cbe_pkg::*;

  logic [7:0]    store [PAYLOAD_DEPTH];
  logic [7:0]    rd_r;
  bk_state_t     st_r, st_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [6:0]    left_r, left_nxt;
  logic          chain;
  cmd_t          c_r, c_nxt;
  logic          ov_r, ov_nxt;
  logic [1:0]    od_r, od_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic          ol_r, ol_nxt;
  logic [1:0]    os_r, os_nxt;
  logic [15:0]   on_r, on_nxt;
  logic [6:0]    lim, room;
  logic [CW-1:0] remain;
  logic          slot, emit, rd_en;
  logic [7:0]    e_b;
  logic [1:0]    e_d;
  logic          e_l;

  always_comb begin
    lim = limit_raw;
    if (lim < 7'd3) lim = 7'd3;
    if (lim > 7'(MAX_FRAME)) lim = 7'(MAX_FRAME);
    room = lim - (cid_en ? 7'd2 : 7'd1);
    remain = (count > pos_r) ? count - pos_r : '0;
  end

  assign slot = !ov_r || out_tready;
  assign send_busy = st_r != BK_IDLE || !cmd_empty;

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr[AW-1:0]] <= wr_data;
    if (rd_en) rd_r <= store[pos_r[AW-1:0]];
  end

  always_comb begin
    st_nxt = st_r; pos_nxt = pos_r; left_nxt = left_r; chain = 1'b0;
    c_nxt = c_r; cmd_pop = 1'b0; rd_en = 1'b0;
    emit = 1'b0; e_b = '0; e_d = DST_CARD; e_l = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (!cmd_empty && slot) begin
          cmd_pop = 1'b1; c_nxt = cmd;
          unique case (cmd.kind)
            CMD_SEND: begin
              if (cmd.has_tail) pos_nxt = '0;
              st_nxt = BK_PCB;
            end
            CMD_HOST: begin
              emit = 1'b1; e_d = DST_HOST; e_b = cmd.b0;
              // last byte of a chained I-block: R-ACK follows
              if (cmd.has_tail) begin
                c_nxt.b0 = cmd.tail; c_nxt.has_tail = 1'b0; st_nxt = BK_TAIL;
              end
            end
            CMD_DONE: begin
              if (cmd.has_tail) begin
                emit = 1'b1; e_d = DST_HOST; e_b = cmd.b0; st_nxt = BK_ONE;
              end else begin
                emit = 1'b1; e_d = DST_DONE; e_l = 1'b1; pos_nxt = '0;
              end
            end
            CMD_SHORT: begin
              emit = 1'b1; e_b = cmd.b0; e_l = !cid_en && !cmd.has_tail;
              st_nxt = cid_en ? BK_CID : (cmd.has_tail ? BK_DATA : BK_IDLE);
            end
            default: ;
          endcase
        end
      end
      BK_ONE: begin
        if (slot) begin
          emit = 1'b1; e_d = DST_DONE; e_l = 1'b1; pos_nxt = '0; st_nxt = BK_IDLE;
        end
      end
      BK_TAIL: begin
        // deferred R-ACK after a forwarded host byte
        if (slot) begin
          emit = 1'b1; e_b = c_r.b0; e_l = !cid_en;
          st_nxt = cid_en ? BK_CID : BK_IDLE;
        end
      end
      BK_PCB: begin
        if (slot) begin
          chain = remain > CW'(room);
          left_nxt = chain ? room : remain[6:0];
          emit = 1'b1;
          e_b = (chain ? PCB_I_CHAIN : PCB_I_LAST) | {4'd0, cid_en, 3'd0} |
                {7'd0, c_r.b0[0]};
          e_l = left_nxt == 7'd0 && !cid_en;
          st_nxt = cid_en ? BK_CID : (left_nxt == 7'd0 ? BK_IDLE : BK_RDREQ);
        end
      end
      BK_CID: begin
        if (slot) begin
          emit = 1'b1; e_b = 8'd0;
          if (c_r.kind == CMD_SEND) begin
            e_l = left_r == 7'd0;
            st_nxt = left_r == 7'd0 ? BK_IDLE : BK_RDREQ;
          end else begin
            e_l = !c_r.has_tail;
            st_nxt = c_r.has_tail ? BK_DATA : BK_IDLE;
          end
        end
      end
      BK_RDREQ: begin
        rd_en = 1'b1; st_nxt = BK_DATA;
      end
      BK_DATA: begin
        if (slot) begin
          emit = 1'b1;
          if (c_r.kind == CMD_SEND) begin
            e_b = (pos_r < CW'(PAYLOAD_DEPTH)) ? rd_r : 8'd0;
            e_l = left_r == 7'd1;
            left_nxt = left_r - 7'd1; pos_nxt = pos_r + 1'b1;
            st_nxt = left_r == 7'd1 ? BK_IDLE : BK_RDREQ;
          end else begin
            e_b = c_r.tail; e_l = 1'b1; st_nxt = BK_IDLE;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r && !out_tready; od_nxt = od_r; ob_nxt = ob_r; ol_nxt = ol_r;
    os_nxt = os_r; on_nxt = on_r;
    if (emit) begin
      ov_nxt = 1'b1; od_nxt = e_d; ob_nxt = e_b; ol_nxt = e_l;
      os_nxt = (e_d == DST_DONE) ? c_r.status : ST_OK;
      on_nxt = (e_d == DST_DONE) ? c_r.len : 16'd0;
      if (st_r == BK_IDLE) begin
        os_nxt = (e_d == DST_DONE) ? cmd.status : ST_OK;
        on_nxt = (e_d == DST_DONE) ? cmd.len : 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; pos_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; pos_r <= pos_nxt; ov_r <= ov_nxt;
    end
    left_r <= left_nxt; c_r <= c_nxt;
    od_r <= od_nxt; ob_r <= ob_nxt; ol_r <= ol_nxt; os_r <= os_nxt; on_r <= on_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tlast = ol_r;
  assign out_tuser = od_r;
  assign out_tdata = {6'd0, on_r, os_r, ob_r};

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (!rst_n) emit |-> slot)
    else $error("overwrite of waiting beat");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_DATA && c_r.kind == CMD_SEND) |-> left_r != 7'd0)
    else $error("data beat with nothing left");
endmodule

// File: sv/contactless_block_exchange.sv
// Reader-side ISO 14443-4 block engine.
// in_ beats: tuser opcode, tdata data_byte, tlast frame_end. Loads fill the
// payload store, start sends the first I-block, card bytes are parsed frame by
// frame.
// out_ beats: tuser destination, tdata byte, status and received length; tlast
// marks the last transmit byte of a frame and completions.
// A front stage parses each input beat and hands at most one work entry at a
// time through a short queue; the back stage turns it into result beats.
// Host bytes, short frames and completions go out as beats when the receiver
// is ready; an I-block is sent as a PCB beat, a CID beat when CID is on, then
// a store read and a data beat for each payload byte.
// The input stalls until the queue is empty and the back stage is idle again,
// so a new item is taken only once the last one is through.
// The store and the back stage's data registers have no reset; reset clears
// counters, toggle, state and config. A stalled receiver holds the output
// register and back-pressures through the queue to in_tready.
module contactless_block_exchange #(
  parameter int PAYLOAD_DEPTH = 256,
  parameter int MAX_FRAME = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic [1:0]  in_tuser,   // opcode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_byte, status, received_length, zero
  output logic [1:0]  out_tuser,  // destination
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cbe_pkg::*;

  localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

  logic          cid_r;
  logic [6:0]    lim_r;
  cmd_t          qin, qout;
  logic          push, full, pop, empty, wr_en, busy;
  logic [CW-1:0] wr_addr, count;
  logic [7:0]    wr_data;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cid_r <= 1'b0; lim_r <= 7'd32;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == CFG_LIMIT[0]) lim_r <= pwdata[6:0];
      else cid_r <= pwdata[0];
    end
  end
  assign prdata = paddr[2] ? {25'd0, lim_r} : {31'd0, cid_r};

  cbe_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .opcode(in_tuser), .data_byte(in_tdata), .frame_end(in_tlast),
    .cid_en(cid_r), .cmd(qin), .cmd_push(push), .cmd_full(full),
    .wr_en, .wr_addr, .wr_data, .count, .send_busy(busy));

  cbe_queue u_queue (.clk, .rst_n, .push, .din(qin), .full, .pop, .empty, .dout(qout));

  cbe_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH), .MAX_FRAME(MAX_FRAME)) u_back (
    .clk, .rst_n, .cid_en(cid_r), .limit_raw(lim_r), .cmd(qout), .cmd_empty(empty),
    .cmd_pop(pop), .count, .send_busy(busy), .wr_en, .wr_addr, .wr_data,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast);
endmodule
